>>> rtl/htmw_pkg.sv
package htmw_pkg;

  // Default sizing of the list store
  localparam int MAX_LIST_DEF    = 64;
  localparam int VERTEX_BITS_DEF = 16;

  // Fixed result field widths
  localparam int COUNT_W  = 7;
  localparam int WEIGHT_W = 19;
  localparam int TOTAL_W  = 48;

  // List selector codes
  localparam logic [1:0] SEL_I    = 2'd0;
  localparam logic [1:0] SEL_J    = 2'd1;
  localparam logic [1:0] SEL_K    = 2'd2;
  localparam logic [1:0] SEL_NONE = 2'd3;

endpackage

>>> rtl/htmw_ram.sv
module htmw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]                       rd_data_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]                       rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read two entries with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> rtl/hyperedge_triple_motif_weight.sv
// Hyperedge triple motif weight.
// Input channel: an item is taken at a clock edge with start high and busy low.
// Each item may append one vertex ID to list i, j or k (in_list_sel); IDs are
// expected ascending within a list. An element sent to a full list (MAX_LIST
// entries) is dropped and flagged. A list selector of three stores nothing.
// Items without in_last_of_triple are taken one per cycle with no result.
// The closing item starts four merge walks over the stored lists: i/j, j/k,
// i/k and i/j/k. Each walk step is a memory read state and a compare state,
// and a walk takes at most len_a+len_b (or the three-list sum) steps and a
// final read state; states S_SUB, S_MUL1, S_MUL2 and S_ACC then form the
// counts, the two-stage product and the saturating total, all with busy high.
// The result appears on the out_ ports for one cycle with out_valid high, in
// the first cycle that busy is low again; a new item may be taken in that same cycle.
// The receiver cannot stall: out_valid is a strobe and is never held.
// List lengths, the overflow flag and the running total clear at reset;
// the list memories are not cleared, only entries of the current triple are
// read. Lengths and the flag return to zero after each result.
module hyperedge_triple_motif_weight
  import htmw_pkg::*;
#(
  parameter int MAX_LIST    = MAX_LIST_DEF,
  parameter int VERTEX_BITS = VERTEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_list_sel,
  input  logic [VERTEX_BITS-1:0] in_vertex_id,
  input  logic                   in_carries_vertex,
  input  logic                   in_last_of_triple,
  input  logic                   in_clear_total,
  output logic                   out_valid,
  output logic [COUNT_W-1:0]     out_only_ij,
  output logic [COUNT_W-1:0]     out_only_jk,
  output logic [COUNT_W-1:0]     out_only_ik,
  output logic [COUNT_W-1:0]     out_common_all,
  output logic [WEIGHT_W-1:0]    out_triple_weight,
  output logic [TOTAL_W-1:0]     out_running_total,
  output logic                   out_list_overflow
);

  localparam int LW       = $clog2(MAX_LIST + 1);
  localparam int AW       = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
  localparam int DEPTH_K  = 2 ** AW;
  localparam int DEPTH_IJ = 2 * DEPTH_K;
  localparam int WW       = 3 * LW;
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LIST);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_CMP  = 7'b0000100,
    S_SUB  = 7'b0001000,
    S_MUL1 = 7'b0010000,
    S_MUL2 = 7'b0100000,
    S_ACC  = 7'b1000000
  } state_t;

  typedef enum logic [3:0] {
    PH_IJ  = 4'b0001,
    PH_JK  = 4'b0010,
    PH_IK  = 4'b0100,
    PH_IJK = 4'b1000
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [LW-1:0] len_i_r, len_j_r, len_k_r;
  logic [LW-1:0] len_i_nxt, len_j_nxt, len_k_nxt;
  logic          ovf_r, ovf_nxt;
  logic          clear_r, clear_nxt;
  logic [LW-1:0] p_r, q_r, r_r, p_nxt, q_nxt, r_nxt;
  logic [LW-1:0] ca_r, cb_r, cc_r, g_r, ca_nxt, cb_nxt, cc_nxt, g_nxt;
  logic [LW-1:0] x_r, y_r, z_r;
  logic [2*LW-1:0] xy_r;
  logic [WW-1:0] w_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] total_base;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_nxt;

  logic accept;
  logic [LW-1:0] sel_len;
  logic          sel_full;
  logic          do_store;

  logic                   ij_wr_en, k_wr_en;
  logic [AW:0]            ij_wr_addr;
  logic [AW:0]            ij_rd_addr_i, ij_rd_addr_j;
  logic [AW-1:0]          k_addr;
  logic [VERTEX_BITS-1:0] vi, vj, vk, vmin;
  logic                   walk_more;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Pick the length of the target list
  always_comb begin
    case (in_list_sel)
      SEL_I:   sel_len = len_i_r;
      SEL_J:   sel_len = len_j_r;
      SEL_K:   sel_len = len_k_r;
      default: sel_len = LEN_MAX;
    endcase
  end

  assign sel_full = (sel_len >= LEN_MAX);
  assign do_store = accept && in_carries_vertex && (in_list_sel != SEL_NONE) && !sel_full;

  // Append into the list memories: i and j share one memory, k has its own
  assign ij_wr_en     = do_store && ((in_list_sel == SEL_I) || (in_list_sel == SEL_J));
  assign k_wr_en      = do_store && (in_list_sel == SEL_K);
  assign ij_wr_addr   = {(in_list_sel == SEL_J), sel_len[AW-1:0]};
  assign ij_rd_addr_i = {1'b0, p_r[AW-1:0]};
  assign ij_rd_addr_j = {1'b1, q_r[AW-1:0]};
  assign k_addr       = do_store ? sel_len[AW-1:0] : r_r[AW-1:0];

  htmw_ram #(
    .WIDTH (VERTEX_BITS),
    .DEPTH (DEPTH_IJ)
  ) u_ram_ij (
    .clk       (clk),
    .wr_en     (ij_wr_en),
    .wr_addr   (ij_wr_addr),
    .wr_data   (in_vertex_id),
    .rd_addr_a (ij_rd_addr_i),
    .rd_data_a (vi),
    .rd_addr_b (ij_rd_addr_j),
    .rd_data_b (vj)
  );

  htmw_ram #(
    .WIDTH (VERTEX_BITS),
    .DEPTH (DEPTH_K)
  ) u_ram_k (
    .clk       (clk),
    .wr_en     (k_wr_en),
    .wr_addr   (sel_len[AW-1:0]),
    .wr_data   (in_vertex_id),
    .rd_addr_a (r_r[AW-1:0]),
    .rd_data_a (vk),
    .rd_addr_b (k_addr),
    .rd_data_b ()
  );

  // Smallest of the three current heads
  always_comb begin
    vmin = (vi < vj) ? vi : vj;
    if (vk < vmin) begin
      vmin = vk;
    end
  end

  // Decide whether the current walk has elements left on all its lists
  always_comb begin
    case (phase_r)
      PH_IJ:   walk_more = (p_r < len_i_r) && (q_r < len_j_r);
      PH_JK:   walk_more = (q_r < len_j_r) && (r_r < len_k_r);
      PH_IK:   walk_more = (p_r < len_i_r) && (r_r < len_k_r);
      PH_IJK:  walk_more = (p_r < len_i_r) && (q_r < len_j_r) && (r_r < len_k_r);
      default: walk_more = 1'b0;
    endcase
  end

  // Sequence loading, merge walks and result forming
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    len_i_nxt = len_i_r;
    len_j_nxt = len_j_r;
    len_k_nxt = len_k_r;
    ovf_nxt   = ovf_r;
    clear_nxt = clear_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    r_nxt     = r_r;
    ca_nxt    = ca_r;
    cb_nxt    = cb_r;
    cc_nxt    = cc_r;
    g_nxt     = g_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_carries_vertex && (in_list_sel != SEL_NONE)) begin
            if (sel_full) begin
              ovf_nxt = 1'b1;
            end else begin
              case (in_list_sel)
                SEL_I:   len_i_nxt = len_i_r + 1'b1;
                SEL_J:   len_j_nxt = len_j_r + 1'b1;
                SEL_K:   len_k_nxt = len_k_r + 1'b1;
                default: len_i_nxt = len_i_r;
              endcase
            end
          end
          if (in_last_of_triple) begin
            clear_nxt = in_clear_total;
            phase_nxt = PH_IJ;
            p_nxt     = '0;
            q_nxt     = '0;
            r_nxt     = '0;
            ca_nxt    = '0;
            cb_nxt    = '0;
            cc_nxt    = '0;
            g_nxt     = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        if (walk_more) begin
          state_nxt = S_CMP;
        end else begin
          p_nxt = '0;
          q_nxt = '0;
          r_nxt = '0;
          case (phase_r)
            PH_IJ:   phase_nxt = PH_JK;
            PH_JK:   phase_nxt = PH_IK;
            PH_IK:   phase_nxt = PH_IJK;
            default: state_nxt = S_SUB;
          endcase
        end
      end
      S_CMP: begin
        state_nxt = S_RD;
        case (phase_r)
          PH_IJ: begin
            if (vi == vj) begin
              ca_nxt = ca_r + 1'b1;
              p_nxt  = p_r + 1'b1;
              q_nxt  = q_r + 1'b1;
            end else if (vi < vj) begin
              p_nxt = p_r + 1'b1;
            end else begin
              q_nxt = q_r + 1'b1;
            end
          end
          PH_JK: begin
            if (vj == vk) begin
              cb_nxt = cb_r + 1'b1;
              q_nxt  = q_r + 1'b1;
              r_nxt  = r_r + 1'b1;
            end else if (vj < vk) begin
              q_nxt = q_r + 1'b1;
            end else begin
              r_nxt = r_r + 1'b1;
            end
          end
          PH_IK: begin
            if (vi == vk) begin
              cc_nxt = cc_r + 1'b1;
              p_nxt  = p_r + 1'b1;
              r_nxt  = r_r + 1'b1;
            end else if (vi < vk) begin
              p_nxt = p_r + 1'b1;
            end else begin
              r_nxt = r_r + 1'b1;
            end
          end
          default: begin
            if ((vi == vj) && (vj == vk)) begin
              g_nxt = g_r + 1'b1;
              p_nxt = p_r + 1'b1;
              q_nxt = q_r + 1'b1;
              r_nxt = r_r + 1'b1;
            end else begin
              if (vi == vmin) p_nxt = p_r + 1'b1;
              if (vj == vmin) q_nxt = q_r + 1'b1;
              if (vk == vmin) r_nxt = r_r + 1'b1;
            end
          end
        endcase
      end
      S_SUB:  state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_ACC;
      S_ACC: begin
        len_i_nxt = '0;
        len_j_nxt = '0;
        len_k_nxt = '0;
        ovf_nxt   = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Saturating add of this weight onto the (optionally cleared) total
  assign total_base = clear_r ? '0 : total_r;
  assign total_sum  = {1'b0, total_base} + (TOTAL_W + 1)'(w_r);
  assign total_nxt  = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= PH_IJ;
      len_i_r   <= '0;
      len_j_r   <= '0;
      len_k_r   <= '0;
      ovf_r     <= 1'b0;
      total_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      len_i_r   <= len_i_nxt;
      len_j_r   <= len_j_nxt;
      len_k_r   <= len_k_nxt;
      ovf_r     <= ovf_nxt;
      out_valid <= (state_r == S_ACC);
      if (state_r == S_ACC) begin
        total_r <= total_nxt;
      end
    end
  end

  // Walk indices, counts and arithmetic pipeline
  always_ff @(posedge clk) begin
    clear_r <= clear_nxt;
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    r_r     <= r_nxt;
    ca_r    <= ca_nxt;
    cb_r    <= cb_nxt;
    cc_r    <= cc_nxt;
    g_r     <= g_nxt;
    if (state_r == S_SUB) begin
      x_r <= (ca_r > g_r) ? ca_r - g_r : '0;
      y_r <= (cb_r > g_r) ? cb_r - g_r : '0;
      z_r <= (cc_r > g_r) ? cc_r - g_r : '0;
    end
    if (state_r == S_MUL1) begin
      xy_r <= x_r * y_r;
    end
    if (state_r == S_MUL2) begin
      w_r <= ((x_r != '0) && (y_r != '0) && (z_r != '0)) ? xy_r * z_r : '0;
    end
  end

  // Capture the result fields for the strobe cycle
  always_ff @(posedge clk) begin
    if (state_r == S_ACC) begin
      out_only_ij       <= COUNT_W'(x_r);
      out_only_jk       <= COUNT_W'(y_r);
      out_only_ik       <= COUNT_W'(z_r);
      out_common_all    <= COUNT_W'(g_r);
      out_triple_weight <= WEIGHT_W'(w_r);
      out_running_total <= total_nxt;
      out_list_overflow <= ovf_r;
    end
  end

`ifndef NO_ASSERTIONS
  // A closing item always starts the walk
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_of_triple) |=> busy)
    else $error("closing item did not start computation");

  // A compare step only happens with every head of the walk inside its list
  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> walk_more)
    else $error("merge walk read past a list end");

  // Lengths never pass the list capacity
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    (len_i_r <= LEN_MAX) && (len_j_r <= LEN_MAX) && (len_k_r <= LEN_MAX))
    else $error("list length beyond capacity");

  // Each result is a single-cycle strobe following the accumulate step
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_ACC) && !busy)
    else $error("result strobe out of sequence");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import htmw_pkg::*;

  localparam int VB = VERTEX_BITS_DEF;
  localparam int ITEM_GOAL = 1450;
  localparam int CALM_AFTER = 1300;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam longint unsigned TOTAL_LIMIT = 64'h0000_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [COUNT_W-1:0]  only_ij;
    logic [COUNT_W-1:0]  only_jk;
    logic [COUNT_W-1:0]  only_ik;
    logic [COUNT_W-1:0]  common_all;
    logic [WEIGHT_W-1:0] weight;
    logic [TOTAL_W-1:0]  total;
    logic                overflow;
  } motif_t;

  // Track the three lists, predict each closed triple and check the results
  class motif_scoreboard;
    logic [VB-1:0] members [3][MAX_LIST_DEF];
    int unsigned fill [3];
    bit dropped;
    longint unsigned weight_sum;
    motif_t expected_q [$];
    int fails;
    int closed;
    int weighted;
    int overflowed;

    function new();
      fill = '{0, 0, 0};
      dropped = 0;
      weight_sum = 0;
      fails = 0;
      closed = 0;
      weighted = 0;
      overflowed = 0;
    endfunction

    function int unsigned pair_overlap(int a, int b);
      int unsigned p, q, n;
      p = 0;
      q = 0;
      n = 0;
      while (p < fill[a] && q < fill[b]) begin
        if (members[a][p] == members[b][q]) begin
          n++;
          p++;
          q++;
        end else if (members[a][p] < members[b][q]) begin
          p++;
        end else begin
          q++;
        end
      end
      return n;
    endfunction

    function int unsigned common_overlap();
      int unsigned p, q, r, n;
      logic [VB-1:0] va, vb, vc, lo;
      p = 0;
      q = 0;
      r = 0;
      n = 0;
      while (p < fill[0] && q < fill[1] && r < fill[2]) begin
        va = members[0][p];
        vb = members[1][q];
        vc = members[2][r];
        if (va == vb && vb == vc) begin
          n++;
          p++;
          q++;
          r++;
        end else begin
          // advance every walk that sits on the smallest value
          lo = (va < vb) ? va : vb;
          if (vc < lo) lo = vc;
          if (va == lo) p++;
          if (vb == lo) q++;
          if (vc == lo) r++;
        end
      end
      return n;
    endfunction

    function void take_item(logic [1:0] sel, logic [VB-1:0] vid, logic carries,
                            logic last, logic clear);
      motif_t m;
      int unsigned ab, bc, ac, g, x, y, z;
      longint unsigned w;
      // append, or drop and flag when the list is full
      if (carries && sel != SEL_NONE) begin
        if (fill[sel] < MAX_LIST_DEF) begin
          members[sel][fill[sel]] = vid;
          fill[sel]++;
        end else begin
          dropped = 1;
        end
      end
      if (!last) return;

      ab = pair_overlap(int'(SEL_I), int'(SEL_J));
      bc = pair_overlap(int'(SEL_J), int'(SEL_K));
      ac = pair_overlap(int'(SEL_I), int'(SEL_K));
      g = common_overlap();
      x = (ab > g) ? ab - g : 0;
      y = (bc > g) ? bc - g : 0;
      z = (ac > g) ? ac - g : 0;
      w = (x > 0 && y > 0 && z > 0) ? longint'(x) * longint'(y) * longint'(z) : 0;

      // saturate the running total
      if (clear) weight_sum = 0;
      if (w > TOTAL_LIMIT - weight_sum) weight_sum = TOTAL_LIMIT;
      else weight_sum += w;

      m.only_ij = x[COUNT_W-1:0];
      m.only_jk = y[COUNT_W-1:0];
      m.only_ik = z[COUNT_W-1:0];
      m.common_all = g[COUNT_W-1:0];
      m.weight = w[WEIGHT_W-1:0];
      m.total = weight_sum[TOTAL_W-1:0];
      m.overflow = dropped;
      expected_q.insert(expected_q.size(), m);

      closed++;
      if (w != 0) weighted++;
      if (dropped) overflowed++;
      fill = '{0, 0, 0};
      dropped = 0;
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned seen);
      if (want != seen) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        fails++;
      end
    endfunction

    function void check_result(motif_t got);
      motif_t want_m;
      if (expected_q.size() == 0) begin
        $error("result strobe with no closed triple waiting");
        fails++;
        return;
      end
      want_m = expected_q.pop_front();
      compare_field("only_ij", 64'(want_m.only_ij), 64'(got.only_ij));
      compare_field("only_jk", 64'(want_m.only_jk), 64'(got.only_jk));
      compare_field("only_ik", 64'(want_m.only_ik), 64'(got.only_ik));
      compare_field("common_all", 64'(want_m.common_all), 64'(got.common_all));
      compare_field("triple_weight", 64'(want_m.weight), 64'(got.weight));
      compare_field("running_total", 64'(want_m.total), 64'(got.total));
      compare_field("list_overflow", 64'(want_m.overflow), 64'(got.overflow));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_list_sel = SEL_I;
  logic [VB-1:0] in_vertex_id = '0;
  logic in_carries_vertex = 1'b0;
  logic in_last_of_triple = 1'b0;
  logic in_clear_total = 1'b0;
  logic out_valid;
  logic [COUNT_W-1:0] out_only_ij;
  logic [COUNT_W-1:0] out_only_jk;
  logic [COUNT_W-1:0] out_only_ik;
  logic [COUNT_W-1:0] out_common_all;
  logic [WEIGHT_W-1:0] out_triple_weight;
  logic [TOTAL_W-1:0] out_running_total;
  logic out_list_overflow;

  motif_scoreboard sb;
  motif_t result_seen;
  int items_taken = 0;
  bit quiet = 1'b0;
  int unsigned cycle_count = 0;

  always #5 clk = ~clk;

  hyperedge_triple_motif_weight i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_list_sel       (in_list_sel),
    .in_vertex_id      (in_vertex_id),
    .in_carries_vertex (in_carries_vertex),
    .in_last_of_triple (in_last_of_triple),
    .in_clear_total    (in_clear_total),
    .out_valid         (out_valid),
    .out_only_ij       (out_only_ij),
    .out_only_jk       (out_only_jk),
    .out_only_ik       (out_only_ik),
    .out_common_all    (out_common_all),
    .out_triple_weight (out_triple_weight),
    .out_running_total (out_running_total),
    .out_list_overflow (out_list_overflow)
  );

  // Check every result strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      result_seen.only_ij = out_only_ij;
      result_seen.only_jk = out_only_jk;
      result_seen.only_ik = out_only_ik;
      result_seen.common_all = out_common_all;
      result_seen.weight = out_triple_weight;
      result_seen.total = out_running_total;
      result_seen.overflow = out_list_overflow;
      sb.check_result(result_seen);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one item, holding it until busy is low at an edge
  task automatic send_item(logic [1:0] sel, logic [VB-1:0] vid, logic carries,
                           logic last, logic clear);
    if (!quiet && items_taken < CALM_AFTER && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_list_sel <= sel;
    in_vertex_id <= vid;
    in_carries_vertex <= carries;
    in_last_of_triple <= last;
    in_clear_total <= clear;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.take_item(sel, vid, carries, last, clear);
    if ((carries && sel != SEL_NONE) || last) items_taken++;
  endtask

  // Hold the sender until every closed triple has reported
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  // Build three lists from a pool of tagged vertices and send them interleaved
  task automatic send_random_triple();
    logic [VB-1:0] lane_v [3][128];
    int lane_n [3];
    int pos [3];
    int shape, pool, step_max, vtx, left, pick, l, k;
    logic [2:0] mask;
    logic [VB-1:0] swap_v;
    bit late_close;
    shape = $urandom_range(0, 29);
    quiet = ($urandom_range(0, 3) == 0);
    lane_n = '{0, 0, 0};
    pos = '{0, 0, 0};
    if (shape < 3) begin
      pool = (shape == 0) ? 64 : (shape == 1) ? 96 : $urandom_range(65, 100);
      step_max = 600;
      vtx = $urandom_range(0, 3000);
    end else begin
      pool = $urandom_range(0, 14);
      step_max = $urandom_range(1, 5000);
      vtx = ($urandom_range(0, 5) == 0) ? $urandom_range(60000, 65535) : $urandom_range(0, 3000);
    end
    for (int p = 0; p < pool && vtx <= 65535; p++) begin
      case (shape)
        0: mask = 3'b111;
        // equal thirds of i/j, j/k and i/k give the largest weight
        1: mask = (p % 3 == 0) ? 3'b011 : (p % 3 == 1) ? 3'b110 : 3'b101;
        2: mask = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : 3'b111;
        default: mask = 3'($urandom_range(1, 7));
      endcase
      for (l = 0; l < 3; l++) begin
        if (mask[l]) begin
          lane_v[l][lane_n[l]] = vtx[VB-1:0];
          lane_n[l]++;
        end
      end
      vtx += $urandom_range(1, step_max);
    end

    // break the order of one list now and then
    if ($urandom_range(0, 7) == 0) begin
      l = $urandom_range(0, 2);
      if (lane_n[l] >= 2) begin
        k = $urandom_range(1, lane_n[l] - 1);
        if ($urandom_range(0, 1) == 1) begin
          swap_v = lane_v[l][k];
          lane_v[l][k] = lane_v[l][k-1];
          lane_v[l][k-1] = swap_v;
        end else begin
          lane_v[l][k] = lane_v[l][k-1];
        end
      end
    end

    left = lane_n[0] + lane_n[1] + lane_n[2];
    late_close = (left == 0) || ($urandom_range(0, 3) == 0);
    while (left > 0) begin
      if ($urandom_range(0, 19) == 0)
        send_item(2'($urandom_range(0, 3)), VB'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 2);
      while (pos[pick] >= lane_n[pick]) pick = (pick + 1) % 3;
      left--;
      send_item(2'(pick), lane_v[pick][pos[pick]], 1'b1, (left == 0 && !late_close),
                1'($urandom_range(0, 7) == 0));
      pos[pick]++;
    end
    if (late_close)
      send_item(2'($urandom_range(0, 3)), VB'($urandom_range(0, 65535)),
                1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 7) == 0));
    if ($urandom_range(0, 9) == 0) drain();
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty triple closed by an ignored selector, with a clear
    send_item(SEL_NONE, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    // extreme IDs, one vertex in each region and one in all three
    send_item(SEL_I, 16'h0000, 1'b1, 1'b0, 1'b1);
    send_item(SEL_J, 16'h0000, 1'b1, 1'b0, 1'b0);
    send_item(SEL_NONE, 16'h1234, 1'b1, 1'b0, 1'b0);
    send_item(SEL_K, 16'd5, 1'b1, 1'b0, 1'b0);
    send_item(SEL_I, 16'd5, 1'b1, 1'b0, 1'b0);
    send_item(SEL_J, 16'd5, 1'b1, 1'b0, 1'b0);
    send_item(SEL_J, 16'hAAAA, 1'b0, 1'b0, 1'b0);
    send_item(SEL_J, 16'd7, 1'b1, 1'b0, 1'b0);
    send_item(SEL_K, 16'd7, 1'b1, 1'b0, 1'b0);
    send_item(SEL_K, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_item(SEL_I, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    // unsorted and repeated lists, closed by an item with no vertex
    send_item(SEL_I, 16'd9, 1'b1, 1'b0, 1'b0);
    send_item(SEL_I, 16'd3, 1'b1, 1'b0, 1'b0);
    send_item(SEL_I, 16'd3, 1'b1, 1'b0, 1'b0);
    send_item(SEL_J, 16'd3, 1'b1, 1'b0, 1'b0);
    send_item(SEL_J, 16'd9, 1'b1, 1'b0, 1'b0);
    send_item(SEL_K, 16'd3, 1'b1, 1'b0, 1'b0);
    send_item(SEL_K, 16'd9, 1'b1, 1'b0, 1'b0);
    send_item(SEL_K, 16'd9, 1'b1, 1'b0, 1'b0);
    send_item(SEL_K, 16'h5555, 1'b0, 1'b1, 1'b1);
    drain();

    while (items_taken < ITEM_GOAL) send_random_triple();

    drain();
    repeat (40) @(posedge clk);
    $display("Sent %0d list and closing items; %0d triples closed, %0d weighted, %0d overflowed.",
             items_taken, sb.closed, sb.weighted, sb.overflowed);
    $display("Mix: empty, full and overfull lists, ignored selectors, late closes, clears.");
    if (sb.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
